@@ rtl/core/angle_interval_coverage_set_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the angle interval coverage set
// Shared clocked implication forms used by the top level checks.
// ---------------------------------------------------------------------------
`ifndef ANGLE_INTERVAL_COVERAGE_SET_DEFINES_SVH
`define ANGLE_INTERVAL_COVERAGE_SET_DEFINES_SVH

// same-cycle implication
`define AICS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AICS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/aics_pkg.sv @@
// ---------------------------------------------------------------------------
// aics_pkg
// Types, codes and constants shared by the angle interval coverage set.
// ---------------------------------------------------------------------------
package aics_pkg;

   localparam int ANGLE_W        = 32;
   localparam int COUNT_W        = 7;
   localparam int MAX_RANGES_DEF = 64;
   localparam logic [ANGLE_W-1:0] ANGLE_TOP = '1;

   typedef enum logic [1:0] {
      CMD_MARK   = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_INVERT = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [ANGLE_W-1:0]   start_angle;
      logic [ANGLE_W-1:0]   end_angle;
   } req_type;

   typedef struct packed {
      logic                 covered;
      logic                 overflow;
      logic [COUNT_W-1:0]   range_count;
   } rsp_type;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_PIECE2,
      DP_CLEAR,
      DP_RD_IDX,
      DP_IDX_INC,
      DP_INS_MERGE,
      DP_RD_M1,
      DP_MRG_EXT,
      DP_MRG_WR,
      DP_RD_K,
      DP_CMP_WR,
      DP_CMP_FIN,
      DP_NEW,
      DP_RD_KM1,
      DP_SHF_WR,
      DP_SHF_FIN,
      DP_OVF,
      DP_QHIT,
      DP_INV_EV,
      DP_INV_FIN
   } dp_op_type;

   typedef struct packed {
      logic idx_end;     // scan index reached count
      logic contained;   // entry holds the piece
      logic overlap;     // entry overlaps the piece
      logic past;        // entry starts after the piece
      logic m_last;      // merge end is the last entry
      logic mrg_more;    // next entry still overlaps
      logic m_eq_idx;    // merge touched a single entry
      logic k_end;       // compaction source reached count
      logic k_at_idx;    // shift reached insert slot
      logic full;        // list is full
      logic q_hit;
      logic q_miss;
      logic inv_stop;
      logic wrap;        // second piece still pending
   } dp_stat_type;

endpackage

@@ rtl/core/aics_ram.sv @@
// ---------------------------------------------------------------------------
// aics_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module aics_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/aics_dp.sv @@
// ---------------------------------------------------------------------------
// aics_dp
// Range list datapath: working registers, compares and the range store.
// ---------------------------------------------------------------------------
module aics_dp #(
   parameter int MAX_RANGES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  aics_pkg::dp_op_type   op,
   input  aics_pkg::req_type     req,
   output aics_pkg::dp_stat_type stat,
   output aics_pkg::rsp_type     rsp
);
   import aics_pkg::*;

   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int AW = $clog2(MAX_RANGES);

   logic [ANGLE_W-1:0] s_ff, s_in, e_ff, e_in, e2_ff, e2_in;
   logic [ANGLE_W-1:0] cursor_ff, cursor_in, mstart_ff, mstart_in, mend_ff, mend_in;
   logic [CW-1:0]      count_ff, count_in, idx_ff, idx_in, m_ff, m_in;
   logic [CW-1:0]      k_ff, k_in, n_ff, n_in;
   logic               wrap_ff, wrap_in, done_ff, done_in;
   logic               ovf_ff, ovf_in, cov_ff, cov_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [2*ANGLE_W-1:0] wr_data, rd_data;
   logic [ANGLE_W-1:0]   rs, re;
   logic [CW-1:0]        m_inc, k_dec;
   logic                 n_full, gap;
   logic [CW+COUNT_W-1:0] count_wide;

   aics_ram #(.WIDTH(2 * ANGLE_W), .DEPTH(MAX_RANGES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rs     = rd_data[2*ANGLE_W-1:ANGLE_W];
   assign re     = rd_data[ANGLE_W-1:0];
   assign m_inc  = m_ff + CW'(1);
   assign k_dec  = k_ff - CW'(1);
   assign n_full = n_ff >= CW'(MAX_RANGES);
   assign gap    = rs > cursor_ff;

   always_comb begin
      stat.idx_end   = idx_ff == count_ff;
      stat.contained = (rs <= s_ff) && (re >= e_ff);
      stat.overlap   = (re >= s_ff) && (rs <= e_ff);
      stat.past      = rs > s_ff;
      stat.m_last    = m_inc == count_ff;
      stat.mrg_more  = rs <= e_ff;
      stat.m_eq_idx  = m_ff == idx_ff;
      stat.k_end     = k_ff == count_ff;
      stat.k_at_idx  = k_ff == idx_ff;
      stat.full      = count_ff >= CW'(MAX_RANGES);
      stat.q_hit     = (s_ff >= rs) && (e_ff <= re);
      stat.q_miss    = e_ff < rs;
      stat.inv_stop  = (idx_ff == count_ff) || done_ff;
      stat.wrap      = wrap_ff;
   end

   // store port control
   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = {s_ff, e_ff};
      case (op)
         DP_RD_M1:  rd_addr = m_inc[AW-1:0];
         DP_RD_K:   rd_addr = k_ff[AW-1:0];
         DP_RD_KM1: rd_addr = k_dec[AW-1:0];
         DP_MRG_WR: begin
            wr_en   = 1'b1;
            wr_data = {mstart_ff, mend_ff};
         end
         DP_CMP_WR: begin
            wr_en   = 1'b1;
            wr_addr = n_ff[AW-1:0];
            wr_data = rd_data;
         end
         DP_SHF_WR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[AW-1:0];
            wr_data = rd_data;
         end
         DP_SHF_FIN: wr_en = 1'b1;
         DP_INV_EV: begin
            wr_en   = gap;
            wr_addr = n_ff[AW-1:0];
            wr_data = {cursor_ff, rs - ANGLE_W'(1)};
         end
         DP_INV_FIN: begin
            wr_en   = !done_ff && !n_full;
            wr_addr = n_ff[AW-1:0];
            wr_data = {cursor_ff, ANGLE_TOP};
         end
         default: ;
      endcase
   end

   always_comb begin
      s_in      = s_ff;
      e_in      = e_ff;
      e2_in     = e2_ff;
      cursor_in = cursor_ff;
      mstart_in = mstart_ff;
      mend_in   = mend_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      m_in      = m_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      wrap_in   = wrap_ff;
      done_in   = done_ff;
      ovf_in    = ovf_ff;
      cov_in    = cov_ff;
      case (op)
         DP_LOAD: begin
            s_in      = req.start_angle;
            wrap_in   = req.start_angle > req.end_angle;
            e_in      = (req.start_angle > req.end_angle) ? ANGLE_TOP : req.end_angle;
            e2_in     = req.end_angle;
            idx_in    = '0;
            n_in      = '0;
            cursor_in = '0;
            done_in   = 1'b0;
            ovf_in    = 1'b0;
            cov_in    = 1'b0;
         end
         DP_PIECE2: begin
            s_in    = '0;
            e_in    = e2_ff;
            wrap_in = 1'b0;
            idx_in  = '0;
         end
         DP_CLEAR:   count_in = '0;
         DP_IDX_INC: idx_in = idx_ff + CW'(1);
         DP_INS_MERGE: begin
            mstart_in = (s_ff < rs) ? s_ff : rs;
            mend_in   = (re > e_ff) ? re : e_ff;
            m_in      = idx_ff;
         end
         DP_MRG_EXT: begin
            m_in    = m_inc;
            mend_in = (re > e_ff) ? re : e_ff;
         end
         DP_MRG_WR: begin
            k_in = m_inc;
            n_in = idx_ff + CW'(1);
         end
         DP_CMP_WR: begin
            k_in = k_ff + CW'(1);
            n_in = n_ff + CW'(1);
         end
         DP_CMP_FIN: count_in = n_ff;
         DP_NEW:     k_in = count_ff;
         DP_SHF_WR:  k_in = k_dec;
         DP_SHF_FIN: count_in = count_ff + CW'(1);
         DP_OVF:     ovf_in = 1'b1;
         DP_QHIT:    cov_in = 1'b1;
         DP_INV_EV: begin
            idx_in = idx_ff + CW'(1);
            if (gap) begin
               n_in = n_ff + CW'(1);
            end
            if (re == ANGLE_TOP) begin
               done_in = 1'b1;
            end else begin
               cursor_in = re + ANGLE_W'(1);
            end
         end
         DP_INV_FIN: begin
            count_in = n_ff;
            if (!done_ff) begin
               if (n_full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = n_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wrap_ff  <= 1'b0;
         done_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         cov_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         wrap_ff  <= wrap_in;
         done_ff  <= done_in;
         ovf_ff   <= ovf_in;
         cov_ff   <= cov_in;
      end
      s_ff      <= s_in;
      e_ff      <= e_in;
      e2_ff     <= e2_in;
      cursor_ff <= cursor_in;
      mstart_ff <= mstart_in;
      mend_ff   <= mend_in;
      idx_ff    <= idx_in;
      m_ff      <= m_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
   end

   // count is reported modulo 2^COUNT_W
   assign count_wide      = {{COUNT_W{1'b0}}, count_ff};
   assign rsp.covered     = cov_ff;
   assign rsp.overflow    = ovf_ff;
   assign rsp.range_count = count_wide[COUNT_W-1:0];

endmodule

@@ rtl/core/aics_ctrl.sv @@
// ---------------------------------------------------------------------------
// aics_ctrl
// Command sequencer: walks the range list one entry per step.
// ---------------------------------------------------------------------------
module aics_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  aics_pkg::cmd_type     req_cmd,
   input  aics_pkg::dp_stat_type stat,
   output aics_pkg::dp_op_type   op,
   output logic                  busy,
   output logic                  rsp_valid
);
   import aics_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INS_RD, ST_INS_EV, ST_INS_NEW, ST_MRG_RD, ST_MRG_EV, ST_MRG_WR,
      ST_CMP_RD, ST_CMP_WR, ST_SHF_RD, ST_SHF_WR, ST_Q_RD, ST_Q_EV, ST_CLR,
      ST_V_RD, ST_V_EV, ST_V_FIN, ST_PIECE2, ST_RESP
   } state_type;

   state_type state_ff, state_in, piece_done;
   cmd_type   cmd_ff, cmd_in;
   logic      busy_ff, rsp_valid_ff;

   assign piece_done = stat.wrap ? ST_PIECE2 : ST_RESP;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      op       = DP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op     = DP_LOAD;
               cmd_in = req_cmd;
               case (req_cmd)
                  CMD_MARK:  state_in = ST_INS_RD;
                  CMD_QUERY: state_in = ST_Q_RD;
                  CMD_CLEAR: state_in = ST_CLR;
                  default:   state_in = ST_V_RD;
               endcase
            end
         end
         ST_INS_RD: begin
            if (stat.idx_end) begin
               state_in = ST_INS_NEW;
            end else begin
               op       = DP_RD_IDX;
               state_in = ST_INS_EV;
            end
         end
         ST_INS_EV: begin
            if (stat.contained) begin
               state_in = piece_done;
            end else if (stat.overlap) begin
               op       = DP_INS_MERGE;
               state_in = ST_MRG_RD;
            end else if (stat.past) begin
               state_in = ST_INS_NEW;
            end else begin
               op       = DP_IDX_INC;
               state_in = ST_INS_RD;
            end
         end
         ST_INS_NEW: begin
            if (stat.full) begin
               op       = DP_OVF;
               state_in = piece_done;
            end else begin
               op       = DP_NEW;
               state_in = ST_SHF_RD;
            end
         end
         ST_SHF_RD: begin
            if (stat.k_at_idx) begin
               op       = DP_SHF_FIN;
               state_in = piece_done;
            end else begin
               op       = DP_RD_KM1;
               state_in = ST_SHF_WR;
            end
         end
         ST_SHF_WR: begin
            op       = DP_SHF_WR;
            state_in = ST_SHF_RD;
         end
         ST_MRG_RD: begin
            if (stat.m_last) begin
               state_in = ST_MRG_WR;
            end else begin
               op       = DP_RD_M1;
               state_in = ST_MRG_EV;
            end
         end
         ST_MRG_EV: begin
            if (stat.mrg_more) begin
               op       = DP_MRG_EXT;
               state_in = ST_MRG_RD;
            end else begin
               state_in = ST_MRG_WR;
            end
         end
         ST_MRG_WR: begin
            op       = DP_MRG_WR;
            state_in = stat.m_eq_idx ? piece_done : ST_CMP_RD;
         end
         ST_CMP_RD: begin
            if (stat.k_end) begin
               op       = DP_CMP_FIN;
               state_in = piece_done;
            end else begin
               op       = DP_RD_K;
               state_in = ST_CMP_WR;
            end
         end
         ST_CMP_WR: begin
            op       = DP_CMP_WR;
            state_in = ST_CMP_RD;
         end
         ST_Q_RD: begin
            if (stat.idx_end) begin
               state_in = ST_RESP;
            end else begin
               op       = DP_RD_IDX;
               state_in = ST_Q_EV;
            end
         end
         ST_Q_EV: begin
            if (stat.q_hit) begin
               if (stat.wrap) begin
                  state_in = ST_PIECE2;
               end else begin
                  op       = DP_QHIT;
                  state_in = ST_RESP;
               end
            end else if (stat.q_miss) begin
               state_in = ST_RESP;
            end else begin
               op       = DP_IDX_INC;
               state_in = ST_Q_RD;
            end
         end
         ST_CLR: begin
            op       = DP_CLEAR;
            state_in = ST_RESP;
         end
         ST_V_RD: begin
            if (stat.inv_stop) begin
               state_in = ST_V_FIN;
            end else begin
               op       = DP_RD_IDX;
               state_in = ST_V_EV;
            end
         end
         ST_V_EV: begin
            op       = DP_INV_EV;
            state_in = ST_V_RD;
         end
         ST_V_FIN: begin
            op       = DP_INV_FIN;
            state_in = ST_RESP;
         end
         ST_PIECE2: begin
            op       = DP_PIECE2;
            state_in = (cmd_ff == CMD_QUERY) ? ST_Q_RD : ST_INS_RD;
         end
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= CMD_MARK;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         busy_ff      <= state_in != ST_IDLE;
         rsp_valid_ff <= state_ff == ST_RESP;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/angle_interval_coverage_set.sv @@
// Work per request: clear walks no entries; query, mark and invert read the range entries
//   visited one at a time, and an insert or a merge also moves the entries behind it.
// Throughput: one request at a time; busy stays high until the response strobe.
// The single read port of the range store paces every walk (registered read, one step per
//   entry). The result strobe rsp_valid lasts one cycle; the receiver cannot stall.
// Reset (synchronous, active high) empties the list at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// angle_interval_coverage_set
// Sorted list of disjoint closed ranges on a 32-bit angle circle with mark,
// query, clear and invert requests.
// ---------------------------------------------------------------------------
`include "angle_interval_coverage_set_defines.svh"

module angle_interval_coverage_set #(
   parameter int MAX_RANGES = aics_pkg::MAX_RANGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  aics_pkg::req_type req_data,
   output logic              rsp_valid,
   output aics_pkg::rsp_type rsp_data
);
   import aics_pkg::*;

   dp_op_type   op;
   dp_stat_type stat;
   logic        accept;

   // A request is taken when start is seen while idle.
   assign accept = start && !busy;

   // Controller: sequences each request over the list, one entry per step.
   aics_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_data.cmd),
      .stat      (stat),
      .op        (op),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: working registers, compares and the range store.
   aics_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .req   (req_data),
      .stat  (stat),
      .rsp   (rsp_data)
   );

   // response strobe only comes out once the block is idle again
   `AICS_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while busy")
   // an accepted request makes the block busy
   `AICS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accept without busy")
   // the strobe lasts one cycle
   `AICS_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe held")

endmodule
